>>> hdl/nsr_pkg.sv
// Shared types and constants for the Newton square root block.
// Used by the controller, the datapath, the top level and the checker.
package nsr_pkg;

    // Fixed field widths.
    localparam int WORD_W  = 32;
    localparam int STEPS_W = 7;
    localparam int TOL_W   = 16;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int DEN_W   = WORD_W + 1;

    // Defaults for the top-level parameters.
    localparam int MAX_STEPS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Quotient bits produced by the bit-serial divider, one per cycle.
    localparam int DIV_BITS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_DIVERGED   = 2'd1,
        ST_LIMIT      = 2'd2,
        ST_ZERO_GUESS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIFF,
        S_DIV,
        S_UPD,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic mul;
        logic div_init;
        logic div_step;
        logic update;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_guess;
        logic finish;
    } t_flags;

endpackage

>>> hdl/nsr_ctrl.sv
// Controller state machine for the Newton square root block.
// Depends on nsr_pkg; drives nsr_dp through t_cmd and reads t_flags.
module nsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    input  nsr_pkg::t_flags i_flags,
    output nsr_pkg::t_cmd   o_cmd
);
    import nsr_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    // The output register can take a new word when empty or being emptied.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);

    // State, divider bit counter and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_bit_cnt   = r_bit_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_flags.zero_guess ? S_FIN : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.div_init = 1'b1;
                n_bit_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit_cnt      = r_bit_cnt + 1'b1;
                if (r_bit_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_flags.finish ? S_FIN : S_MUL;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/nsr_dp.sv
// Datapath for the Newton square root block: multiplier, bit-serial
// divider, step update and result registers. Depends on nsr_pkg.
module nsr_dp #(
    parameter int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nsr_pkg::t_cmd               i_cmd,
    output nsr_pkg::t_flags             o_flags,
    input  logic                        i_cfg_valid,
    input  logic [nsr_pkg::TOL_W-1:0]   i_cfg_tolerance,
    input  logic [nsr_pkg::WORD_W-1:0]  i_radicand,
    input  logic [nsr_pkg::WORD_W-1:0]  i_initial_guess,
    output logic [nsr_pkg::WORD_W-1:0]  o_root,
    output logic [nsr_pkg::STEPS_W-1:0] o_steps_taken,
    output logic [1:0]                  o_status
);
    import nsr_pkg::*;

    logic [TOL_W-1:0]   r_tol;
    logic [WORD_W-1:0]  r_n, r_g, r_prev;
    logic               r_have_prev;
    logic [STEPS_W-1:0] r_steps;
    logic [PROD_W-1:0]  r_sq;
    logic               r_ge;
    logic [DEN_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_quo;
    logic [WORD_W-1:0]  r_res_root;
    logic [STEPS_W-1:0] r_res_steps;
    t_status            r_res_status;
    logic [WORD_W-1:0]  r_root;
    logic [STEPS_W-1:0] r_steps_out;
    t_status            r_status_out;

    logic [PROD_W-1:0]  nn;
    logic [DEN_W-1:0]   den;
    logic [DEN_W:0]     rem_sh;
    logic               q_bit;
    logic [WORD_W-1:0]  sub_wide;
    logic [PROD_W:0]    sum_wide;
    logic [WORD_W-1:0]  g_next, step;
    logic [STEPS_W-1:0] steps_nx;
    logic               diverged, converged, at_limit;

    // Radicand at the scale of the square, divisor 2g.
    assign nn  = {{WORD_W{1'b0}}, r_n} << FRAC_BITS;
    assign den = {r_g, 1'b0};

    // One restoring division step: shift in the next dividend bit, compare.
    assign rem_sh = {r_rem, r_quo[PROD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, den});

    // Next guess: subtract the correction, or add it with saturation.
    // A downward correction never exceeds g/2, so it fits in a word.
    assign sub_wide = r_g - r_quo[WORD_W-1:0];
    assign sum_wide = {{(WORD_W+1){1'b0}}, r_g} + {1'b0, r_quo};
    always_comb begin
        if (r_ge) begin
            g_next = sub_wide;
        end else if (sum_wide > {{(WORD_W+1){1'b0}}, {WORD_W{1'b1}}}) begin
            g_next = {WORD_W{1'b1}};
        end else begin
            g_next = sum_wide[WORD_W-1:0];
        end
    end

    // Step size and the stop tests; divergence takes precedence.
    assign step      = (g_next >= r_g) ? (g_next - r_g) : (r_g - g_next);
    assign steps_nx  = r_steps + 1'b1;
    assign diverged  = r_have_prev && (step > r_prev);
    assign converged = (step <= {{(WORD_W-TOL_W){1'b0}}, r_tol});
    assign at_limit  = (steps_nx == STEPS_W'(MAX_STEPS));

    assign o_flags.zero_guess = (r_g == '0);
    assign o_flags.finish     = diverged || converged || at_limit;

    // Tolerance register, written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_tolerance;
        end
    end

    // Working registers of the iteration.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n         <= i_radicand;
            r_g         <= i_initial_guess;
            r_have_prev <= 1'b0;
            r_steps     <= '0;
        end
        if (i_cmd.check) begin
            r_res_root   <= '0;
            r_res_steps  <= '0;
            r_res_status <= ST_ZERO_GUESS;
        end
        if (i_cmd.mul) begin
            r_sq <= r_g * r_g;
        end
        if (i_cmd.div_init) begin
            r_ge  <= (r_sq >= nn);
            r_quo <= (r_sq >= nn) ? (r_sq - nn) : (nn - r_sq);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], q_bit};
        end
        if (i_cmd.update) begin
            r_steps     <= steps_nx;
            r_res_steps <= steps_nx;
            if (diverged) begin
                r_res_root   <= r_g;
                r_res_status <= ST_DIVERGED;
            end else if (converged) begin
                r_res_root   <= g_next;
                r_res_status <= ST_CONVERGED;
            end else begin
                r_res_root   <= g_next;
                r_res_status <= ST_LIMIT;
                r_g          <= g_next;
                r_prev       <= step;
                r_have_prev  <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_root       <= r_res_root;
            r_steps_out  <= r_res_steps;
            r_status_out <= r_res_status;
        end
    end

    assign o_root        = r_root;
    assign o_steps_taken = r_steps_out;
    assign o_status      = r_status_out;

endmodule

>>> hdl/newton_square_root_core.sv
// Top level of the Newton square root block: controller plus datapath.
// Depends on nsr_pkg, nsr_ctrl and nsr_dp.
//
// Usage:
// Input channel: i_in_valid with i_radicand and i_initial_guess (unsigned,
// FRAC_BITS fraction bits); the block holds o_in_stall high while busy.
// Output channel: o_out_valid with o_root, o_steps_taken and o_status; the
// receiver holds i_out_stall high to keep the word in place.
// Configuration: i_cfg_tolerance is written when i_cfg_valid is high;
// o_cfg_ready is always high. Write only while the block is idle.
// Sequence: after acceptance the block checks the guess, then runs k Newton
// steps (k = 0 for a zero guess) before its word is loaded for output. Each
// step forms the square, forms the dividend, runs the bit-serial divider
// and then updates the guess. One item is in work at a time; the next is
// accepted while a finished word still waits in the output register. If
// that register is still full when the next result is ready, the block
// waits until the receiver takes it.
// Reset (synchronous, active low) empties the output register, returns the
// controller to idle and sets the tolerance to 1.
module newton_square_root_core #(
    parameter int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [nsr_pkg::WORD_W-1:0]  i_radicand,
    input  logic [nsr_pkg::WORD_W-1:0]  i_initial_guess,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nsr_pkg::WORD_W-1:0]  o_root,
    output logic [nsr_pkg::STEPS_W-1:0] o_steps_taken,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [nsr_pkg::TOL_W-1:0]   i_cfg_tolerance
);
    import nsr_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    nsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    // Arithmetic and result registers.
    nsr_dp #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_flags         (flags),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_tolerance (i_cfg_tolerance),
        .i_radicand      (i_radicand),
        .i_initial_guess (i_initial_guess),
        .o_root          (o_root),
        .o_steps_taken   (o_steps_taken),
        .o_status        (o_status)
    );

endmodule

>>> hdl/nsr_checker.sv
// Port-level checker for newton_square_root_core, attached by bind.
// Depends on nsr_pkg.
module nsr_checker #(
    parameter int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [nsr_pkg::WORD_W-1:0]  o_root,
    input logic [nsr_pkg::STEPS_W-1:0] o_steps_taken,
    input logic [1:0]                  o_status
);
    import nsr_pkg::*;

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_root)
            && $stable(o_steps_taken) && $stable(o_status))
        else $error("stalled result word changed");

    // A zero guess reports a zero root after no steps.
    a_zero_guess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ZERO_GUESS)
            |-> (o_root == '0) && (o_steps_taken == '0))
        else $error("zero guess result malformed");

    // Any other outcome took at least one step and no more than the limit.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_ZERO_GUESS)
            |-> (o_steps_taken != '0) && (o_steps_taken <= STEPS_W'(MAX_STEPS)))
        else $error("step count out of range");

    // The step limit status comes only with the full step count.
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_LIMIT)
            |-> (o_steps_taken == STEPS_W'(MAX_STEPS)))
        else $error("step limit reported early");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind newton_square_root_core nsr_checker #(
    .MAX_STEPS (MAX_STEPS)
) u_nsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_root        (o_root),
    .o_steps_taken (o_steps_taken),
    .o_status      (o_status)
);

>>> sim/tb_newton_square_root_core.sv
// Self-checking testbench for newton_square_root_core: a clocked driver, a receiver and
// a monitor that checks every result word against a Newton step predictor.
// Depends on nsr_pkg and the newton_square_root_core RTL.
module tb_newton_square_root_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nsr_pkg::*;

    localparam int MAX_STEPS  = MAX_STEPS_DEF;
    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int IDLE_PCT   = 7;
    localparam int HOLD_LEN   = 2500;
    localparam int TAIL_WAIT  = 300;
    localparam int RAND_ITEMS = 70;

    typedef struct packed {
        logic [WORD_W-1:0] radicand;
        logic [WORD_W-1:0] guess;
    } t_sqrt_item;

    typedef struct packed {
        logic [WORD_W-1:0]  root;
        logic [STEPS_W-1:0] steps;
        t_status            status;
    } t_root_word;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic [WORD_W-1:0]   i_radicand      = '0;
    logic [WORD_W-1:0]   i_initial_guess = '0;
    logic                i_out_stall     = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic [TOL_W-1:0]    i_cfg_tolerance = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [WORD_W-1:0]   o_root;
    logic [STEPS_W-1:0]  o_steps_taken;
    logic [1:0]          o_status;
    logic                o_cfg_ready;

    t_sqrt_item   pending_items[$];
    t_root_word   expected_roots[$];
    t_sqrt_item   next_item;
    t_root_word   want_word;
    logic [TOL_W-1:0] tol_now = TOL_RESET;
    bit           word_sent   = 1'b0;
    bit           send_steady = 1'b0;
    bit           recv_steady = 1'b0;
    int           hold_left   = 0;
    int           error_count = 0;
    int           words_taken = 0;
    int           words_seen  = 0;
    int           tol_writes  = 0;
    int           most_steps  = 0;
    int           status_seen[4] = '{0, 0, 0, 0};

    newton_square_root_core #(
        .MAX_STEPS(MAX_STEPS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_radicand     (i_radicand),
        .i_initial_guess(i_initial_guess),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_root         (o_root),
        .o_steps_taken  (o_steps_taken),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_tolerance(i_cfg_tolerance)
    );

    // One Newton step in fixed point, with saturation on the upward correction.
    function automatic logic [WORD_W-1:0] newton_next(input logic [WORD_W-1:0] n,
                                                      input logic [WORD_W-1:0] g);
        logic [PROD_W-1:0] square, scaled_n, twice_g, corr, total;
        square   = PROD_W'(g) * PROD_W'(g);
        scaled_n = PROD_W'(n) << FRAC_BITS;
        twice_g  = PROD_W'(g) << 1;
        if (square >= scaled_n) begin
            corr = (square - scaled_n) / twice_g;
            return g - corr[WORD_W-1:0];
        end
        corr  = (scaled_n - square) / twice_g;
        total = PROD_W'(g) + corr;
        if (total > PROD_W'({WORD_W{1'b1}})) begin
            total = PROD_W'({WORD_W{1'b1}});
        end
        return total[WORD_W-1:0];
    endfunction

    // Full iteration for one word: convergence, divergence, step limit or zero guess.
    function automatic t_root_word predict_root(input logic [WORD_W-1:0] n,
                                                input logic [WORD_W-1:0] g0,
                                                input logic [TOL_W-1:0]  tol);
        t_root_word        w;
        logic [WORD_W-1:0] g, g_next, step_size, prev_size;
        bit                have_prev;
        int                count;
        w.root   = '0;
        w.steps  = '0;
        w.status = ST_ZERO_GUESS;
        if (g0 == '0) begin
            return w;
        end
        g         = g0;
        prev_size = '0;
        have_prev = 1'b0;
        count     = 0;
        w.root    = g0;
        w.status  = ST_LIMIT;
        while (count < MAX_STEPS) begin
            g_next    = newton_next(n, g);
            step_size = (g_next >= g) ? g_next - g : g - g_next;
            count++;
            // A growing step ends the run before the tolerance is looked at.
            if (have_prev && step_size > prev_size) begin
                w.root   = g;
                w.status = ST_DIVERGED;
                break;
            end
            if (step_size <= WORD_W'(tol)) begin
                w.root   = g_next;
                w.status = ST_CONVERGED;
                break;
            end
            prev_size = step_size;
            have_prev = 1'b1;
            g         = g_next;
            w.root    = g_next;
        end
        w.steps = STEPS_W'(count);
        return w;
    endfunction

    // Well-formed words start from a guess offset or scaled from the true root; the rest are raw noise.
    function automatic t_sqrt_item rand_item(input bit well_formed);
        t_sqrt_item item;
        real        exact, start;
        item.radicand = $urandom() >> $urandom_range(0, 31);
        if (!well_formed) begin
            if ($urandom_range(0, 3) == 0) begin
                item.radicand = $urandom();
            end
            item.guess = ($urandom_range(0, 24) == 0) ? '0 : $urandom() >> $urandom_range(0, 31);
            return item;
        end
        exact = $sqrt(real'(item.radicand) * real'(64'd1 << FRAC_BITS));
        case ($urandom_range(0, 2))
            0: begin
                start = exact + real'($urandom_range(0, 64)) - 32.0;
            end
            1: begin
                start = exact * (0.5 + real'($urandom_range(0, 1500)) / 1000.0);
            end
            default: begin
                start = exact * real'($urandom_range(1, 64));
            end
        endcase
        if (start < 1.0) begin
            start = 1.0;
        end
        if (start > 4294967295.0) begin
            start = 4294967295.0;
        end
        item.guess = WORD_W'(longint'(start));
        return item;
    endfunction

    task automatic queue_item(input logic [WORD_W-1:0] n, input logic [WORD_W-1:0] g);
        pending_items.push_back('{radicand: n, guess: g});
    endtask

    task automatic queue_random(input int count);
        repeat (count) begin
            pending_items.push_back(rand_item($urandom_range(0, 99) < 75));
        end
    endtask

    // Waits until every word has been offered, taken and answered.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_roots.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_tolerance <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        tol_now = value;
        tol_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [TOL_W-1:0] tol, input int count);
        wait_idle();
        set_tolerance(tol);
        queue_random(count);
    endtask

    // Clock with a 10 ns period.
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Input driver: offers the next pending word, holding it until it is taken.
    always @(negedge i_clk) begin
        if (!i_in_valid || word_sent) begin
            word_sent = 1'b0;
            if (i_rst_n && pending_items.size() != 0 &&
                (send_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item = pending_items.pop_front();
                i_in_valid      <= 1'b1;
                i_radicand      <= next_item.radicand;
                i_initial_guess <= next_item.guess;
            end else begin
                i_in_valid      <= 1'b0;
                i_radicand      <= $urandom();
                i_initial_guess <= $urandom();
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !recv_steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Monitor: predicts each accepted word and checks each delivered result.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            word_sent = 1'b1;
            words_taken++;
            expected_roots.push_back(predict_root(i_radicand, i_initial_guess, tol_now));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            if (expected_roots.size() == 0) begin
                $error("result word with nothing expected: root %h steps %0d status %0d",
                       o_root, o_steps_taken, o_status);
                error_count++;
            end else begin
                want_word = expected_roots.pop_front();
                if (o_root !== want_word.root) begin
                    $error("root: expected %h, actual %h", want_word.root, o_root);
                    error_count++;
                end
                if (o_steps_taken !== want_word.steps) begin
                    $error("steps_taken: expected %0d, actual %0d", want_word.steps,
                           o_steps_taken);
                    error_count++;
                end
                if (o_status !== want_word.status) begin
                    $error("status: expected %0d, actual %0d", want_word.status, o_status);
                    error_count++;
                end
                status_seen[want_word.status]++;
                if (int'(want_word.steps) > most_steps) begin
                    most_steps = int'(want_word.steps);
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, zero guess, zero radicand and saturation, at the reset tolerance.
        queue_item(32'h0000_0000, 32'h0000_0000);
        queue_item(32'hFFFF_FFFF, 32'h0000_0000);
        queue_item(32'h0000_0000, 32'h0000_0001);
        queue_item(32'h0000_0000, 32'hFFFF_FFFF);
        queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(32'hFFFF_FFFF, 32'h0000_0001);
        queue_item(32'h0001_0000, 32'h0001_0000);
        queue_item(32'h0004_0000, 32'h0001_0000);
        queue_item(32'h0002_0000, 32'h0001_6A09);
        queue_item(32'hAAAA_AAAA, 32'h5555_5555);
        queue_item(32'h5555_5555, 32'hAAAA_AAAA);
        queue_item(32'h0000_0001, 32'h0000_0001);
        queue_item(32'h0001_0000, 32'hFFFF_FFFF);
        queue_item(32'hFFFF_FFFF, 32'h00FF_FFFF);
        queue_item(32'h8000_0000, 32'h00B5_04F3);

        // Zero tolerance: only an exact fixed point converges, so truncation
        // near the root shows equal steps, divergence and the step limit.
        wait_idle();
        set_tolerance('0);
        queue_item(32'h0002_0000, 32'h0001_6A09);
        queue_item(32'h0003_0000, 32'h0001_BB67);
        queue_item(32'h0000_0002, 32'h0000_0001);
        queue_item(32'h0005_0000, 32'h0002_3C6E);
        queue_item(32'h0009_0000, 32'h0003_0000);
        queue_random(60);

        run_phase({TOL_W{1'b1}}, 60);

        // Long receiver hold-off with short words, so the block backs up.
        wait_idle();
        set_tolerance(TOL_W'(16));
        send_steady = 1'b1;
        hold_left   = HOLD_LEN;
        repeat (30) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_item($urandom(), '0);
            end else begin
                automatic int k = $urandom_range(1, 255);
                queue_item(WORD_W'(k * k) << FRAC_BITS, WORD_W'(k) << FRAC_BITS);
            end
        end

        // A stretch with no idling on either side.
        wait_idle();
        recv_steady = 1'b1;
        set_tolerance(TOL_W'($urandom_range(0, 65535)));
        queue_random(80);
        wait_idle();
        send_steady = 1'b0;
        recv_steady = 1'b0;

        run_phase(TOL_W'($urandom_range(2, 65534)), RAND_ITEMS);
        run_phase(TOL_RESET, RAND_ITEMS);
        run_phase(TOL_W'($urandom_range(0, 64)), RAND_ITEMS);

        wait_idle();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("Checked %0d of %0d accepted words over %0d tolerance writes, up to %0d steps.",
                 words_seen, words_taken, tol_writes, most_steps);
        $display("Status mix: %0d converged, %0d diverged, %0d step limit, %0d zero guess.",
                 status_seen[ST_CONVERGED], status_seen[ST_DIVERGED], status_seen[ST_LIMIT],
                 status_seen[ST_ZERO_GUESS]);
        if (error_count == 0) begin
            $display("tb_newton_square_root_core passed");
        end else begin
            $display("tb_newton_square_root_core failed");
        end
        $finish;
    end

    // Watchdog: far beyond a run in which every word hits the step limit.
    initial begin
        #50_000_000;
        $display("tb_newton_square_root_core failed");
        $finish;
    end

endmodule

>>> newton_square_root_core.f
hdl/nsr_pkg.sv
hdl/nsr_ctrl.sv
hdl/nsr_dp.sv
hdl/newton_square_root_core.sv
hdl/nsr_checker.sv
sim/tb_newton_square_root_core.sv
